/* rtl/stu_pkg.sv */
// stu_pkg: shared types, character codes and digit decode for the string to
// unsigned parser and its checker
// no dependencies
package stu_pkg;

    localparam int unsigned VALUE_BITS_DEF = 32;

    localparam int unsigned CH_W     = 8;
    localparam int unsigned RADIX_W  = 6;
    localparam int unsigned RESULT_W = 32;
    localparam int unsigned OFFSET_W = 16;

    localparam logic [RADIX_W-1:0] RADIX_RESET = 6'd10;
    localparam logic [RADIX_W-1:0] BASE_AUTO   = 6'd0;
    localparam logic [RADIX_W-1:0] BASE_MIN    = 6'd2;
    localparam logic [RADIX_W-1:0] BASE_OCT    = 6'd8;
    localparam logic [RADIX_W-1:0] BASE_DEC    = 6'd10;
    localparam logic [RADIX_W-1:0] BASE_HEX    = 6'd16;
    localparam logic [RADIX_W-1:0] BASE_MAX    = 6'd36;
    localparam logic [RADIX_W-1:0] DIGIT_NONE  = 6'd63;

    localparam logic [CH_W-1:0] CH_NUL   = 8'h00;
    localparam logic [CH_W-1:0] CH_TAB   = 8'h09;
    localparam logic [CH_W-1:0] CH_SPACE = 8'h20;
    localparam logic [CH_W-1:0] CH_PLUS  = 8'h2B;
    localparam logic [CH_W-1:0] CH_MINUS = 8'h2D;
    localparam logic [CH_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [CH_W-1:0] CH_NINE  = 8'h39;
    localparam logic [CH_W-1:0] CH_UP_A  = 8'h41;
    localparam logic [CH_W-1:0] CH_UP_X  = 8'h58;
    localparam logic [CH_W-1:0] CH_UP_Z  = 8'h5A;
    localparam logic [CH_W-1:0] CH_LO_A  = 8'h61;
    localparam logic [CH_W-1:0] CH_LO_X  = 8'h78;
    localparam logic [CH_W-1:0] CH_LO_Z  = 8'h7A;

    typedef struct packed {
        logic [CH_W-1:0] ch;
        logic            first;
    } t_in_word;

    typedef struct packed {
        logic [RESULT_W-1:0] result;
        logic [OFFSET_W-1:0] end_offset;
        logic                done_res;
    } t_out_word;

    // digit value of a character, DIGIT_NONE when it is no digit at all
    function automatic logic [RADIX_W-1:0] digit_value(input logic [CH_W-1:0] c);
        logic [CH_W-1:0] d;
        begin
            d = CH_W'(DIGIT_NONE);
            if (c >= CH_ZERO && c <= CH_NINE) begin
                d = c - CH_ZERO;
            end else if (c >= CH_UP_A && c <= CH_UP_Z) begin
                d = c - CH_UP_A + 8'd10;
            end else if (c >= CH_LO_A && c <= CH_LO_Z) begin
                d = c - CH_LO_A + 8'd10;
            end
            return d[RADIX_W-1:0];
        end
    endfunction

endpackage

/* rtl/string_to_unsigned_parser_top.sv */
// string_to_unsigned_parser_top: strtoul style parser, one character a word
// depends on stu_pkg
// a result word is registered in the cycle after its character is accepted
// throughput: one character per cycle, one multiply-add by the base per word
// input stalls only while the output register is full and stalled
// reset: synchronous, active low; clears parse state and output valid, radix = 10
module string_to_unsigned_parser_top
    import stu_pkg::*;
#(
    parameter int unsigned VALUE_BITS = VALUE_BITS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [RADIX_W-1:0]  i_cfg_data,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  t_in_word            i_in_word,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output t_out_word           o_out_word
);

    typedef enum logic [2:0] {
        PH_BLANK   = 3'd0,
        PH_BASE    = 3'd1,
        PH_HEXZERO = 3'd2,
        PH_AUTOZ   = 3'd3,
        PH_DIGITS  = 3'd4,
        PH_DONE    = 3'd5
    } t_phase;

    localparam int unsigned PROD_W = VALUE_BITS + RADIX_W;

    logic [RADIX_W-1:0]    r_radix;
    t_phase                r_phase,  n_phase;
    logic                  r_neg,    n_neg;
    logic [VALUE_BITS-1:0] r_acc,    n_acc;
    logic [RADIX_W-1:0]    r_base,   n_base;
    logic [OFFSET_W-1:0]   r_cnt,    n_cnt;
    logic                  r_out_valid;
    t_out_word             r_out_word, n_out_word;

    t_phase                e_phase;
    logic                  e_neg;
    logic [VALUE_BITS-1:0] e_acc;
    logic [RADIX_W-1:0]    e_base;
    logic [OFFSET_W-1:0]   e_cnt;

    logic                  in_acc;
    logic                  out_acc;
    logic [CH_W-1:0]       c;
    logic                  c_is_x;
    logic [RADIX_W-1:0]    cfg_base;
    logic [RADIX_W-1:0]    sel_base;
    logic [RADIX_W-1:0]    digit;
    logic                  pick;
    logic                  do_digit;
    logic                  count;
    logic [PROD_W-1:0]     prod;
    logic [VALUE_BITS-1:0] signed_val;
    logic [63:0]           val_ext;

    assign out_acc    = r_out_valid && !i_out_stall;
    assign o_in_stall = r_out_valid && i_out_stall;
    assign in_acc     = i_in_valid && !o_in_stall;

    assign c      = i_in_word.ch;
    assign c_is_x = (c == CH_LO_X) || (c == CH_UP_X);
    assign digit  = digit_value(c);

    assign cfg_base = (r_radix < BASE_MIN || r_radix > BASE_MAX) ? BASE_DEC : r_radix;

    // a first word clears the state before its character is handled
    assign e_phase = i_in_word.first ? PH_BLANK : r_phase;
    assign e_neg   = i_in_word.first ? 1'b0 : r_neg;
    assign e_acc   = i_in_word.first ? '0 : r_acc;
    assign e_base  = i_in_word.first ? BASE_DEC : r_base;
    assign e_cnt   = i_in_word.first ? '0 : r_cnt;

    assign prod = e_acc * sel_base;

    always_comb begin
        n_phase  = e_phase;
        n_neg    = e_neg;
        n_base   = e_base;
        n_acc    = e_acc;
        sel_base = e_base;
        pick     = 1'b0;
        do_digit = 1'b0;
        count    = 1'b0;

        unique case (e_phase)
            PH_BLANK: begin
                if (c == CH_SPACE || c == CH_TAB) begin
                    count = 1'b1;
                end else if (c == CH_MINUS) begin
                    n_neg   = 1'b1;
                    count   = 1'b1;
                    n_phase = PH_BASE;
                end else if (c == CH_PLUS) begin
                    count   = 1'b1;
                    n_phase = PH_BASE;
                end else begin
                    pick = 1'b1;
                end
            end
            PH_BASE: begin
                pick = 1'b1;
            end
            PH_HEXZERO: begin
                if (c_is_x) begin
                    count   = 1'b1;
                    n_phase = PH_DIGITS;
                end else begin
                    do_digit = 1'b1;
                end
            end
            PH_AUTOZ: begin
                if (c_is_x) begin
                    n_base  = BASE_HEX;
                    count   = 1'b1;
                    n_phase = PH_DIGITS;
                end else begin
                    n_base   = BASE_OCT;
                    sel_base = BASE_OCT;
                    do_digit = 1'b1;
                end
            end
            PH_DIGITS: begin
                do_digit = 1'b1;
            end
            PH_DONE: begin
                n_phase = PH_DONE;
            end
            default: begin
                n_phase = PH_DONE;
            end
        endcase

        // base selection from the radix register
        if (pick) begin
            if (r_radix == BASE_HEX) begin
                n_base = BASE_HEX;
                if (c == CH_ZERO) begin
                    count   = 1'b1;
                    n_phase = PH_HEXZERO;
                end else begin
                    sel_base = BASE_HEX;
                    do_digit = 1'b1;
                end
            end else if (r_radix == BASE_AUTO) begin
                if (c == CH_ZERO) begin
                    n_base  = BASE_OCT;
                    count   = 1'b1;
                    n_phase = PH_AUTOZ;
                end else begin
                    n_base   = BASE_DEC;
                    sel_base = BASE_DEC;
                    do_digit = 1'b1;
                end
            end else begin
                n_base   = cfg_base;
                sel_base = cfg_base;
                do_digit = 1'b1;
            end
        end

        if (do_digit) begin
            if (digit < sel_base) begin
                n_acc   = prod[VALUE_BITS-1:0] + VALUE_BITS'(digit);
                count   = 1'b1;
                n_phase = PH_DIGITS;
            end else begin
                n_phase = PH_DONE;
            end
        end

        n_cnt = e_cnt;
        if (count && e_cnt != '1) begin
            n_cnt = e_cnt + 1'b1;
        end

        signed_val = n_neg ? (VALUE_BITS'(0) - n_acc) : n_acc;
        val_ext    = 64'(signed_val);

        n_out_word.result     = val_ext[RESULT_W-1:0];
        n_out_word.end_offset = n_cnt;
        n_out_word.done_res   = (n_phase == PH_DONE);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radix     <= RADIX_RESET;
            r_phase     <= PH_BLANK;
            r_neg       <= 1'b0;
            r_acc       <= '0;
            r_base      <= BASE_DEC;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_radix <= i_cfg_data;
            end
            if (in_acc) begin
                r_phase     <= n_phase;
                r_neg       <= n_neg;
                r_acc       <= n_acc;
                r_base      <= n_base;
                r_cnt       <= n_cnt;
                r_out_valid <= 1'b1;
            end else if (out_acc) begin
                r_out_valid <= 1'b0;
            end
        end
        if (in_acc) begin
            r_out_word <= n_out_word;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

endmodule

/* rtl/stu_chk.sv */
// stu_chk: port level checks for string_to_unsigned_parser_top, bound to it
// depends on stu_pkg and string_to_unsigned_parser_top
module stu_chk
    import stu_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_in_valid,
    input logic      o_in_stall,
    input t_in_word  i_in_word,
    input logic      o_out_valid,
    input logic      i_out_stall,
    input t_out_word o_out_word
);

    // a stalled result word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_out_word)))
        else $error("stalled result word changed");

    // every accepted character gives a result word in the next cycle
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_out_valid)
        else $error("no result word after accepted character");

    // input is only held off by a full, stalled output register
    a_stall_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (o_out_valid && i_out_stall))
        else $error("input stalled without output back-pressure");

    // an empty string ends at once with nothing consumed
    a_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall && i_in_word.first && i_in_word.ch == CH_NUL)
        |=> (o_out_word.done_res && o_out_word.end_offset == '0
             && o_out_word.result == '0))
        else $error("empty string result wrong");

endmodule

bind string_to_unsigned_parser_top stu_chk u_stu_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .i_in_word   (i_in_word),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_word  (o_out_word)
);
